// File: hdl/ibsc_pkg.sv
// ----------------------------------------------------------------------------
// ibsc_pkg
// Shared types, register map and helpers for the imu bias and scale correction
// ----------------------------------------------------------------------------
`default_nettype none

package ibsc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = 14;
    localparam int COUNT_W    = 12;
    localparam int SUM_W      = SAMPLE_W + COUNT_W;
    localparam int PROD_W     = COEF_W + DIFF_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int SAT_IN_W   = 36;
    localparam int AXES       = 3;
    localparam int ROW_W      = 48;
    localparam int STEP_W     = $clog2(SUM_W);
    localparam int WORD_W     = AXES * 2 * SAMPLE_W;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;

    localparam logic [2:0] REG_CAL_ENABLE  = 3'd0;
    localparam logic [2:0] REG_CAL_COUNT   = 3'd1;
    localparam logic [2:0] REG_ACCEL_OFFS  = 3'd2;
    localparam logic [2:0] REG_SCALE_ROW_X = 3'd3;
    localparam logic [2:0] REG_SCALE_ROW_Y = 3'd4;
    localparam logic [2:0] REG_SCALE_ROW_Z = 3'd5;

    localparam logic [COUNT_W-1:0] CAL_COUNT_RST = 12'd100;
    localparam logic [ROW_W-1:0] ROW_X_RST = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0] ROW_Y_RST = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RST = 48'h4000_0000_0000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DIV_END,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic acc_en;
        logic div_start;
        logic div_step;
        logic div_done;
        logic mac_en;
        logic sum_en;
    } lane_ctl_t;

    function automatic sample_t sat_sample(input logic signed [SAT_IN_W-1:0] v);
        sample_t r;
        if (v > SAT_IN_W'(signed'(32767))) begin
            r = 16'sh7fff;
        end else if (v < -SAT_IN_W'(signed'(32768))) begin
            r = 16'sh8000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ibsc_lane.sv
// ----------------------------------------------------------------------------
// ibsc_lane
// One axis: gyro sum and bias divide, accel row dot product, gyro correction
// ----------------------------------------------------------------------------
`default_nettype none

module ibsc_lane
    import ibsc_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire lane_ctl_t               ctl,
    input  wire logic [ROW_W-1:0]        row,
    input  wire diff_t                   diff [AXES],
    input  wire sample_t                 rate,
    input  wire logic [COUNT_W-1:0]      div_count,
    output sample_t                      fixed_accel,
    output sample_t                      fixed_rate
);

    logic signed [SUM_W-1:0]  sum_reg;
    sample_t                  bias_reg;
    logic [SUM_W-1:0]         quo_reg;
    logic [COUNT_W-1:0]       rem_reg;
    logic                     neg_reg;
    logic signed [PROD_W-1:0] prod_reg [AXES];
    logic signed [DIFF_W-1:0] rdiff_reg;
    sample_t                  acc_out_reg;
    sample_t                  rate_out_reg;

    logic [COUNT_W:0]         shifted;
    logic                     qbit;
    logic [COUNT_W:0]         rem_sub;
    logic signed [DOT_W-1:0]  dot;
    logic signed [DOT_W-COEF_FRAC-1:0] scaled;
    logic signed [SAT_IN_W-1:0] quo_signed;

    // one restoring divide step per cycle
    always_comb begin
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        rem_sub = shifted - {1'b0, div_count};
        qbit    = (shifted >= {1'b0, div_count});
    end

    always_comb begin
        dot = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1]) + DOT_W'(prod_reg[2])
            + DOT_W'(signed'(1 << (COEF_FRAC - 1)));
        // dropping the fraction bits floors the rounded sum
        scaled = dot[DOT_W-1:COEF_FRAC];
        quo_signed = neg_reg ? -$signed({{(SAT_IN_W-SUM_W){1'b0}}, quo_reg})
                             :  $signed({{(SAT_IN_W-SUM_W){1'b0}}, quo_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            bias_reg <= '0;
        end else begin
            if (ctl.acc_en) begin
                sum_reg <= sum_reg + SUM_W'(rate);
            end
            if (ctl.div_done) begin
                bias_reg <= sat_sample(quo_signed);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.div_start) begin
            neg_reg <= sum_reg[SUM_W-1];
            quo_reg <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
            rem_reg <= '0;
        end else if (ctl.div_step) begin
            rem_reg <= qbit ? rem_sub[COUNT_W-1:0] : shifted[COUNT_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], qbit};
        end
        if (ctl.mac_en) begin
            for (int j = 0; j < AXES; j++) begin
                prod_reg[j] <= PROD_W'($signed(row[COEF_W*j +: COEF_W]))
                             * PROD_W'(diff[j]);
            end
            rdiff_reg <= DIFF_W'(rate) - DIFF_W'(bias_reg);
        end
        if (ctl.sum_en) begin
            acc_out_reg  <= sat_sample(SAT_IN_W'(scaled));
            rate_out_reg <= sat_sample(SAT_IN_W'(rdiff_reg));
        end
    end

    assign fixed_accel = acc_out_reg;
    assign fixed_rate  = rate_out_reg;

endmodule

`default_nettype wire

// File: hdl/ibsc_merge.sv
// ----------------------------------------------------------------------------
// ibsc_merge
// Gathers the three lane results into one output word with its own register
// ----------------------------------------------------------------------------
`default_nettype none

module ibsc_merge
    import ibsc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire sample_t           lane_accel [AXES],
    input  wire sample_t           lane_rate [AXES],
    output logic                   free,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [WORD_W-1:0]      m_tdata
);

    logic              valid_reg;
    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            data_next[SAMPLE_W*i +: SAMPLE_W]        = lane_accel[i];
            data_next[SAMPLE_W*(AXES+i) +: SAMPLE_W] = lane_rate[i];
        end
    end

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

// File: hdl/imu_bias_scale_correction_top.sv
// ----------------------------------------------------------------------------
// imu_bias_scale_correction_top
// Gyro bias learning and accelerometer offset and scale-matrix correction
// ----------------------------------------------------------------------------
// Usage: one input word on s_ carries a raw six-axis sample. While gyro
// calibration is enabled and not done, the gyro axes are summed and no word
// comes out; on the sample that completes the count each of three lanes runs
// a one-bit-per-cycle restoring divide to form its bias. Otherwise one word
// leaves on m_ with the corrected accel and gyro axes.
// A correcting sample is taken into an input register, then passes the MUL,
// SUM and OUT states; a calibration sample only adds to the sums, and the
// final one also runs the 28 divide steps.
// One sample is processed at a time: s_tready is high only when idle.
// The result sits in an output register, so a new sample is taken while the
// previous result waits; a stalled m_tready holds the word and, once the next
// result is ready, holds the pipeline.
// Reset (aresetn low, synchronous) clears the sums, sample count, bias and
// done flag and restores the registers to their defaults.
// APB registers sit at byte address 8*i, 64-bit data, pready always high.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_bias_scale_correction_top
    import ibsc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each)
    input  wire logic [WORD_W-1:0]     s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // fixed_accel_x/y/z, fixed_rate_x/y/z (16 bits each)
    output logic [WORD_W-1:0]          m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic               cal_en_reg;
    logic [COUNT_W-1:0] cal_count_reg;
    logic [ROW_W-1:0]   offs_reg;
    logic [ROW_W-1:0]   row_reg [AXES];

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [COUNT_W-1:0] seen_reg;
    logic [COUNT_W-1:0] seen_next;
    logic [COUNT_W-1:0] count_eff;
    logic               done_reg;
    logic [WORD_W-1:0]  in_reg;

    lane_ctl_t          ctl;
    logic               merge_load;
    logic               merge_free;
    logic               in_take;
    logic               wr_en;
    logic [2:0]         reg_idx;

    diff_t              diff [AXES];
    sample_t            lane_accel [AXES];
    sample_t            lane_rate [AXES];

    // configuration port
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_en_reg    <= 1'b1;
            cal_count_reg <= CAL_COUNT_RST;
            offs_reg      <= '0;
            row_reg[0]    <= ROW_X_RST;
            row_reg[1]    <= ROW_Y_RST;
            row_reg[2]    <= ROW_Z_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CAL_ENABLE:  cal_en_reg    <= pwdata[0];
                REG_CAL_COUNT:   cal_count_reg <= pwdata[COUNT_W-1:0];
                REG_ACCEL_OFFS:  offs_reg      <= pwdata[ROW_W-1:0];
                REG_SCALE_ROW_X: row_reg[0]    <= pwdata[ROW_W-1:0];
                REG_SCALE_ROW_Y: row_reg[1]    <= pwdata[ROW_W-1:0];
                REG_SCALE_ROW_Z: row_reg[2]    <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CAL_ENABLE:  prdata = APB_DATA_W'(cal_en_reg);
            REG_CAL_COUNT:   prdata = APB_DATA_W'(cal_count_reg);
            REG_ACCEL_OFFS:  prdata = APB_DATA_W'(offs_reg);
            REG_SCALE_ROW_X: prdata = APB_DATA_W'(row_reg[0]);
            REG_SCALE_ROW_Y: prdata = APB_DATA_W'(row_reg[1]);
            REG_SCALE_ROW_Z: prdata = APB_DATA_W'(row_reg[2]);
            default:         prdata = '0;
        endcase
    end

    // sequencer
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_take   = s_tvalid && s_tready;
    assign seen_next = seen_reg + 1'b1;
    assign count_eff = (cal_count_reg == '0) ? COUNT_W'(1) : cal_count_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    state_next = (cal_en_reg && !done_reg) ? ST_ACC : ST_MUL;
                end
            end
            ST_ACC: begin
                state_next = (seen_next >= count_eff) ? ST_DIV_LOAD : ST_IDLE;
            end
            ST_DIV_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END: state_next = ST_IDLE;
            ST_MUL:     state_next = ST_SUM;
            ST_SUM:     state_next = ST_OUT;
            ST_OUT: begin
                if (merge_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl        = '0;
        merge_load = 1'b0;
        unique case (state_reg)
            ST_ACC:      ctl.acc_en    = 1'b1;
            ST_DIV_LOAD: ctl.div_start = 1'b1;
            ST_DIV:      ctl.div_step  = 1'b1;
            ST_DIV_END:  ctl.div_done  = 1'b1;
            ST_MUL:      ctl.mac_en    = 1'b1;
            ST_SUM:      ctl.sum_en    = 1'b1;
            ST_OUT:      merge_load    = merge_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seen_reg  <= '0;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (ctl.acc_en) begin
                seen_reg <= seen_next;
            end
            if (ctl.div_done) begin
                done_reg <= 1'b1;
            end
            if (ctl.div_step) begin
                step_reg <= step_reg + 1'b1;
            end else begin
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_reg <= s_tdata;
        end
    end

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            diff[i] = DIFF_W'($signed(in_reg[SAMPLE_W*i +: SAMPLE_W]))
                    - DIFF_W'($signed(offs_reg[SAMPLE_W*i +: SAMPLE_W]));
        end
    end

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        ibsc_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .row         (row_reg[g]),
            .diff        (diff),
            .rate        (in_reg[SAMPLE_W*(AXES+g) +: SAMPLE_W]),
            .div_count   (seen_reg),
            .fixed_accel (lane_accel[g]),
            .fixed_rate  (lane_rate[g])
        );
    end

    ibsc_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (merge_load),
        .lane_accel (lane_accel),
        .lane_rate  (lane_rate),
        .free       (merge_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

// File: hdl/ibsc_checker.sv
// ----------------------------------------------------------------------------
// ibsc_checker
// Port-level checks on the correction block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ibsc_checker
    import ibsc_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [WORD_W-1:0] m_tdata,
    input wire logic              pready
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // one sample in flight: input closes right after a word is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // no result can appear straight after a word is taken if none was pending
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind imu_bias_scale_correction_top ibsc_checker u_ibsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

`default_nettype wire

// File: verif/imu_bias_scale_correction_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_bias_scale_correction_top_tb
// Self-checking bench: streams raw six-axis samples into s_, reprograms the
// registers over apb between phases and checks every m_ word against a
// behavioural model of gyro bias learning and accel offset and matrix
// correction, with random gaps and back-pressure on both sides
// ----------------------------------------------------------------------------

module imu_bias_scale_correction_top_tb;
    import ibsc_pkg::*;

    localparam int LIMIT  = 400000;
    localparam int SETTLE = 64;
    localparam int HOLD   = 400;

    typedef logic [WORD_W-1:0] word_t;

    class imu_corr_checker;
        bit                      cal_en;
        logic [COUNT_W-1:0]      cal_count;
        logic [ROW_W-1:0]        accel_offs;
        logic [ROW_W-1:0]        scale_row [AXES];
        logic signed [SUM_W-1:0] rate_sum [AXES];
        logic [COUNT_W-1:0]      seen;
        sample_t                 rate_bias [AXES];
        bit                      cal_done;
        word_t                   corrected_q [$];
        int                      errors;

        function new();
            cal_en       = 1'b1;
            cal_count    = CAL_COUNT_RST;
            accel_offs   = '0;
            scale_row[0] = ROW_X_RST;
            scale_row[1] = ROW_Y_RST;
            scale_row[2] = ROW_Z_RST;
            for (int i = 0; i < AXES; i++) begin
                rate_sum[i]  = '0;
                rate_bias[i] = '0;
            end
            seen     = '0;
            cal_done = 1'b0;
            errors   = 0;
        endfunction

        function sample_t clamp16(longint v);
            if (v > 32767) return 16'sh7fff;
            if (v < -32768) return 16'sh8000;
            return sample_t'(v);
        endfunction

        function void write_reg(logic [2:0] idx, logic [APB_DATA_W-1:0] v);
            case (idx)
                REG_CAL_ENABLE:  cal_en       = v[0];
                REG_CAL_COUNT:   cal_count    = v[COUNT_W-1:0];
                REG_ACCEL_OFFS:  accel_offs   = v[ROW_W-1:0];
                REG_SCALE_ROW_X: scale_row[0] = v[ROW_W-1:0];
                REG_SCALE_ROW_Y: scale_row[1] = v[ROW_W-1:0];
                REG_SCALE_ROW_Z: scale_row[2] = v[ROW_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [APB_DATA_W-1:0] reg_value(logic [2:0] idx);
            case (idx)
                REG_CAL_ENABLE:  return APB_DATA_W'(cal_en);
                REG_CAL_COUNT:   return APB_DATA_W'(cal_count);
                REG_ACCEL_OFFS:  return APB_DATA_W'(accel_offs);
                REG_SCALE_ROW_X: return APB_DATA_W'(scale_row[0]);
                REG_SCALE_ROW_Y: return APB_DATA_W'(scale_row[1]);
                REG_SCALE_ROW_Z: return APB_DATA_W'(scale_row[2]);
                default:         return '0;
            endcase
        endfunction

        // predicts the corrected word for one accepted sample, if there is one
        function void note_sample(word_t w);
            sample_t acc [AXES];
            sample_t rate [AXES];
            sample_t offs;
            sample_t c;
            longint  diff [AXES];
            longint  dot;
            int      cnt;
            word_t   res;
            for (int i = 0; i < AXES; i++) begin
                acc[i]  = w[SAMPLE_W*i +: SAMPLE_W];
                rate[i] = w[SAMPLE_W*(AXES+i) +: SAMPLE_W];
            end
            if (cal_en && !cal_done) begin
                // a count of zero behaves as one
                cnt = (cal_count == 0) ? 1 : int'(cal_count);
                for (int i = 0; i < AXES; i++)
                    rate_sum[i] = rate_sum[i] + rate[i];
                seen = seen + 1'b1;
                if (int'(seen) >= cnt) begin
                    for (int i = 0; i < AXES; i++)
                        rate_bias[i] = clamp16(longint'(rate_sum[i]) / longint'(seen));
                    cal_done = 1'b1;
                end
                return;
            end
            for (int j = 0; j < AXES; j++) begin
                offs    = accel_offs[16*j +: 16];
                diff[j] = longint'(acc[j]) - longint'(offs);
            end
            for (int i = 0; i < AXES; i++) begin
                dot = 0;
                for (int j = 0; j < AXES; j++) begin
                    c = scale_row[i][16*j +: 16];
                    dot += longint'(c) * diff[j];
                end
                // round half up, then floor by the fraction bits
                dot += longint'(1) <<< (COEF_FRAC - 1);
                res[SAMPLE_W*i +: SAMPLE_W] = clamp16(dot >>> COEF_FRAC);
            end
            for (int i = 0; i < AXES; i++)
                res[SAMPLE_W*(AXES+i) +: SAMPLE_W] =
                    clamp16(longint'(rate[i]) - longint'(rate_bias[i]));
            corrected_q.push_back(res);
        endfunction

        task report(string what);
            errors++;
            // keep the log short on a badly broken run
            if (errors <= 100)
                $display("mismatch: %s", what);
        endtask

        task check_word(word_t w);
            word_t want;
            string names [2*AXES] = '{"fixed_accel_x", "fixed_accel_y", "fixed_accel_z",
                                      "fixed_rate_x", "fixed_rate_y", "fixed_rate_z"};
            if (corrected_q.size() == 0) begin
                report($sformatf("word %h with nothing expected", w));
                return;
            end
            want = corrected_q.pop_front();
            for (int k = 0; k < 2*AXES; k++) begin
                if (w[SAMPLE_W*k +: SAMPLE_W] !== want[SAMPLE_W*k +: SAMPLE_W])
                    report($sformatf("%s got %0d want %0d", names[k],
                                     signed'(w[SAMPLE_W*k +: SAMPLE_W]),
                                     signed'(want[SAMPLE_W*k +: SAMPLE_W])));
            end
        endtask
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    word_t                 s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    word_t                 m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic calm      = 1'b0;
    logic hold_req  = 1'b0;
    int   hold_left = 0;
    int   cycles    = 0;

    imu_corr_checker chk = new();

    imu_bias_scale_correction_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            chk.note_sample(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            chk.check_word(m_tdata);
    end

    // receiver: random back-pressure, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  <= 1'b0;
            hold_left = HOLD;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 31);
        end
    end

    function automatic word_t pack6(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
                                    logic [15:0] a3, logic [15:0] a4, logic [15:0] a5);
        return {a5, a4, a3, a2, a1, a0};
    endfunction

    function automatic logic [ROW_W-1:0] pack3(logic [15:0] c0, logic [15:0] c1,
                                               logic [15:0] c2);
        return {c2, c1, c0};
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(64) - 32);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic word_t rand_sample();
        word_t w;
        for (int i = 0; i < 2*AXES; i++)
            w[SAMPLE_W*i +: SAMPLE_W] = rand_axis();
        return w;
    endfunction

    // still samples with a strong offset, so the learnt bias is large
    function automatic word_t cal_sample();
        return pack6(rand_axis(), rand_axis(), rand_axis(),
                     16'($urandom_range(32767, 20000)),
                     16'(32'd65536 - $urandom_range(32768, 20000)),
                     rand_axis());
    endfunction

    function automatic logic [ROW_W-1:0] rand_row(int kind, int axis);
        logic [ROW_W-1:0] r;
        logic [15:0]      extremes [4] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
        for (int j = 0; j < AXES; j++) begin
            case (kind)
                0:       r[16*j +: 16] = ((j == axis) ? 16'h4000 : 16'h0000)
                                         + 16'($urandom_range(1024) - 512);
                2:       r[16*j +: 16] = extremes[$urandom_range(3)];
                default: r[16*j +: 16] = 16'($urandom());
            endcase
        end
        return r;
    endfunction

    // write, then read back in a second transfer
    task program_reg(logic [2:0] idx, logic [APB_DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        chk.write_reg(idx, v);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== chk.reg_value(idx))
            chk.report($sformatf("register %0d read %h want %h",
                                 idx, prdata, chk.reg_value(idx)));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task send_sample(word_t w);
        while (!calm && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // drain all expected words and let a calibration divide finish
    task end_phase();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chk.corrected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [APB_DATA_W-1:0] offs;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // straight correction with a zero bias
        program_reg(REG_CAL_ENABLE, 0);
        program_reg(REG_CAL_COUNT, 4095);
        send_sample(pack6(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_sample(pack6(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        send_sample(pack6(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_sample(pack6(16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h8000));
        end_phase();

        // extreme gains and offsets push the rows into saturation on full-scale samples
        program_reg(REG_ACCEL_OFFS, pack3(16'h8000, 16'h7fff, 16'h0000));
        program_reg(REG_SCALE_ROW_X, pack3(16'h7fff, 16'h7fff, 16'h7fff));
        program_reg(REG_SCALE_ROW_Y, pack3(16'h8000, 16'h8000, 16'h8000));
        program_reg(REG_SCALE_ROW_Z, pack3(16'h7fff, 16'h8000, 16'h0001));
        send_sample(pack6(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        send_sample(pack6(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_sample(pack6(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_sample(pack6(16'h8000, 16'h7fff, 16'h1234, 16'h7fff, 16'h8000, 16'h0000));
        end_phase();

        // half gains land the rounding exactly on ties of both signs
        program_reg(REG_ACCEL_OFFS, 0);
        program_reg(REG_SCALE_ROW_X, pack3(16'h2000, 16'h0000, 16'h0000));
        program_reg(REG_SCALE_ROW_Y, pack3(16'h0000, 16'he000, 16'h0000));
        program_reg(REG_SCALE_ROW_Z, pack3(16'h0000, 16'h0000, 16'h0001));
        send_sample(pack6(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001));
        send_sample(pack6(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        send_sample(pack6(16'h0003, 16'hfffd, 16'h2000, 16'h0003, 16'hfffd, 16'h2000));
        send_sample(pack6(16'hfffd, 16'h0003, 16'he000, 16'hfffd, 16'h0003, 16'he000));
        end_phase();

        // start learning, pause it with enable low, then carry on
        program_reg(REG_CAL_ENABLE, 1);
        send_sample(pack6(16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h7fff, 16'h7fff));
        send_sample(pack6(16'h8000, 16'h7fff, 16'h0000, 16'h8000, 16'h8000, 16'h8000));
        send_sample(pack6(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0001));
        repeat (3) send_sample(cal_sample());
        end_phase();
        program_reg(REG_CAL_ENABLE, 0);
        repeat (2) send_sample(rand_sample());
        end_phase();
        program_reg(REG_CAL_ENABLE, 1);
        repeat (150) send_sample(cal_sample());
        end_phase();

        // count dropped to zero under the samples seen: the next one finishes
        program_reg(REG_CAL_COUNT, 0);
        send_sample(cal_sample());
        end_phase();

        for (int p = 0; p < 5; p++) begin
            program_reg(REG_CAL_ENABLE, APB_DATA_W'($urandom_range(1)));
            program_reg(REG_CAL_COUNT, (p % 2) ? 4095 : 1);
            case (p)
                1, 4:    offs = '0;
                2:       offs = pack3(16'h8000, 16'h7fff, 16'h8000);
                default: offs = {$urandom(), $urandom()};
            endcase
            program_reg(REG_ACCEL_OFFS, offs);
            if (p == 4) begin
                program_reg(REG_SCALE_ROW_X, ROW_X_RST);
                program_reg(REG_SCALE_ROW_Y, ROW_Y_RST);
                program_reg(REG_SCALE_ROW_Z, ROW_Z_RST);
            end else begin
                program_reg(REG_SCALE_ROW_X, rand_row(p, 0));
                program_reg(REG_SCALE_ROW_Y, rand_row(p, 1));
                program_reg(REG_SCALE_ROW_Z, rand_row(p, 2));
            end
            calm <= (p == 1);
            if (p == 2)
                hold_req <= 1'b1;
            repeat (236) send_sample(rand_sample());
            end_phase();
        end

        if (chk.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
